### design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants for the base64 stream decoder
// Character classes, end status codes, queue sizing and the alphabet map.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Queue between the classifier and the decode stage
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_PAD,
    KIND_BAD
  } b64d_kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_CHAR,
    ST_BAD_LEN
  } b64d_status_t;

  // One classified character as it travels through the queue
  typedef struct packed {
    b64d_kind_t  kind;
    logic [5:0]  sextet;
    logic        last;
  } b64d_item_t;

  // Returns {invalid, sextet}
  function automatic logic [6:0] map_char(input logic [7:0] c, input logic url);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      return {1'b0, d[5:0]};
    end
    if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      return {1'b0, d[5:0]};
    end
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      return {1'b0, d[5:0]};
    end
    if (url) begin
      if (c == 8'h2D) return {1'b0, 6'd62};
      if (c == 8'h5F) return {1'b0, 6'd63};
    end else begin
      if (c == 8'h2B) return {1'b0, 6'd62};
      if (c == 8'h2F) return {1'b0, 6'd63};
    end
    return {1'b1, 6'd0};
  endfunction

endpackage

### design/b64d_in_if.sv
// ----------------------------------------------------------------------------
// b64d_in_if: encoded character channel
// One character per transfer, with a flag on the final character.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

### design/b64d_out_if.sv
// ----------------------------------------------------------------------------
// b64d_out_if: decoded result channel
// A decoded byte, an end-of-string status, or both, per transfer.
// ----------------------------------------------------------------------------
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_string;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_valid,
                  output end_of_string, output status, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input end_of_string, input status, output ready);
endinterface

### design/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: input classifier
// Holds the alphabet register, maps each character to a class and sextet.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                clk,
  input  logic                rst_n,
  b64d_in_if.sink             in_ch,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                q_full,
  output logic                q_push,
  output b64d_pkg::b64d_item_t q_item
);

  logic       url_r;
  logic       url_nxt;
  logic [6:0] mapped;

  always_comb begin
    url_nxt = url_r;
    if (cfg_we) begin
      url_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_r <= 1'b0;
    end else begin
      url_r <= url_nxt;
    end
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign mapped      = b64d_pkg::map_char(in_ch.char_in, url_r);

  always_comb begin
    q_item.sextet = mapped[5:0];
    q_item.last   = in_ch.last_char;
    if (in_ch.char_in == b64d_pkg::PAD_CHAR) begin
      q_item.kind = b64d_pkg::KIND_PAD;
    end else if (mapped[6]) begin
      q_item.kind = b64d_pkg::KIND_BAD;
    end else begin
      q_item.kind = b64d_pkg::KIND_DATA;
    end
  end

endmodule

### design/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue: short FIFO of classified characters
// Decouples the classifier from the decode stage.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  b64d_pkg::b64d_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output b64d_pkg::b64d_item_t head
);

  b64d_pkg::b64d_item_t                   mem_r [b64d_pkg::QDEPTH];
  logic [b64d_pkg::QPTR_W-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [b64d_pkg::QPTR_W-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [b64d_pkg::QCNT_W-1:0]            cnt_r, cnt_nxt;
  logic                                   do_push, do_pop;

  assign full      = (cnt_r == b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == b64d_pkg::QPTR_W'(b64d_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == b64d_pkg::QPTR_W'(b64d_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH))
    else $error("queue count above depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");
`endif

endmodule

### design/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: decode stage
// Tracks group phase, padding and errors; registers one result per transfer.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  b64d_pkg::b64d_item_t q_item,
  output logic                 q_pop,
  b64d_out_if.source           out_ch
);

  logic [5:0] prev_r, prev_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       pad_r, pad_nxt;
  logic       bad_r, bad_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       bv_r, bv_nxt;
  logic       eos_r, eos_nxt;
  logic [1:0] status_r, status_nxt;

  logic       have_byte;
  logic [7:0] dec_byte;
  logic       take;

  // Pop whenever the output register is free or being drained this cycle
  assign take  = !out_valid_r || out_ch.ready;
  assign q_pop = q_valid && take;

  always_comb begin
    prev_nxt  = prev_r;
    phase_nxt = phase_r;
    pad_nxt   = pad_r;
    bad_nxt   = bad_r;
    have_byte = 1'b0;
    dec_byte  = 8'd0;
    if (q_pop && !pad_r && !bad_r) begin
      unique case (q_item.kind)
        b64d_pkg::KIND_PAD: pad_nxt = 1'b1;
        b64d_pkg::KIND_BAD: bad_nxt = 1'b1;
        b64d_pkg::KIND_DATA: begin
          unique case (phase_r)
            2'd1: begin
              dec_byte  = {prev_r, q_item.sextet[5:4]};
              have_byte = 1'b1;
            end
            2'd2: begin
              dec_byte  = {prev_r[3:0], q_item.sextet[5:2]};
              have_byte = 1'b1;
            end
            2'd3: begin
              dec_byte  = {prev_r[1:0], q_item.sextet};
              have_byte = 1'b1;
            end
            default: ;
          endcase
          prev_nxt  = q_item.sextet;
          phase_nxt = phase_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    byte_nxt      = byte_r;
    bv_nxt        = bv_r;
    eos_nxt       = eos_r;
    status_nxt    = status_r;
    if (q_pop && (have_byte || q_item.last)) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = dec_byte;
      bv_nxt        = have_byte;
      eos_nxt       = q_item.last;
      status_nxt    = b64d_pkg::ST_OK;
      if (q_item.last) begin
        if (bad_nxt) begin
          status_nxt = b64d_pkg::ST_BAD_CHAR;
        end else if (phase_nxt == 2'd1) begin
          status_nxt = b64d_pkg::ST_BAD_LEN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      phase_r     <= '0;
      pad_r       <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop && q_item.last) begin
        prev_r  <= '0;
        phase_r <= '0;
        pad_r   <= 1'b0;
        bad_r   <= 1'b0;
      end else begin
        prev_r  <= prev_nxt;
        phase_r <= phase_nxt;
        pad_r   <= pad_nxt;
        bad_r   <= bad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    bv_r     <= bv_nxt;
    eos_r    <= eos_nxt;
    status_r <= status_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = byte_r;
  assign out_ch.byte_valid    = bv_r;
  assign out_ch.end_of_string = eos_r;
  assign out_ch.status        = status_r;

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.last) |=> (phase_r == 2'd0 && !pad_r && !bad_r && prev_r == 6'd0))
    else $error("string state not cleared after final character");

  a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != b64d_pkg::ST_OK) |-> eos_r)
    else $error("error status on a non-final result");

  a_bad_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (bad_r && !(q_pop && q_item.last)) |=> (bad_r && $stable(phase_r)))
    else $error("phase moved after invalid character");
`endif

endmodule

### design/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 decoder, one character per transfer
//
// in_ch  : one encoded character per transfer, last_char on the final one.
// out_ch : a decoded byte (byte_valid) and/or, on the final character, the
//          end status: ok, invalid character, or bad length (orphan char).
//          Characters that complete no byte and are not final give nothing.
// cfg_we / cfg_wdata : alphabet select, 0 standard (+ /), 1 URL-safe (- _).
//          Write only while the decoder is idle.
// Path: the transfer edge writes the classifier queue, then the output
//          register is loaded from the queue head. Throughput is one
//          character per cycle while out_ch does not stall.
// A two-entry queue sits between classifier and decode stage; when out_ch
//          stalls the queue fills and in_ch.ready drops, with no loss.
// On a nonzero status, discard every byte already delivered for the string.
// Reset clears the queue, the string state and the alphabet (standard).
// ----------------------------------------------------------------------------
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  b64d_in_if.sink     in_ch,
  b64d_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  b64d_pkg::b64d_item_t push_item;
  b64d_pkg::b64d_item_t head;
  logic                 push, full, pop, not_empty;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (full),
    .q_push    (push),
    .q_item    (push_item)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  b64d_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (not_empty),
    .q_item  (head),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for base64_stream_decoder
// Drives encoded strings one character per transfer, predicts each decoded
// byte and end status in step, and checks every output transfer against it.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [7:0]             out_byte;
    logic                   byte_valid;
    logic                   end_of_string;
    b64d_pkg::b64d_status_t status;
  } dec_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  b64d_in_if  in_ch ();
  b64d_out_if out_ch ();

  base64_stream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // decoder state as predicted
  logic       url_mode;
  logic [5:0] prev_sext;
  logic [1:0] phase;
  logic       pad_seen;
  logic       bad_seen;

  dec_result_t pending_decodes[$];
  logic [7:0]  char_buf[$];
  int          live_chars;
  int          err_count;
  int          src_idle_pct;
  int          snk_idle_pct;

  always #5 clk = ~clk;

  // {invalid, value} of one character under the given alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c, input logic url);
    logic [7:0] t;
    t = 8'd0;
    if (c >= "A" && c <= "Z") begin
      t = c - "A";
    end else if (c >= "a" && c <= "z") begin
      t = c - "a" + 8'd26;
    end else if (c >= "0" && c <= "9") begin
      t = c - "0" + 8'd52;
    end else if (c == (url ? "-" : "+")) begin
      t = 8'd62;
    end else if (c == (url ? "_" : "/")) begin
      t = 8'd63;
    end else begin
      return {1'b1, 6'd0};
    end
    return {1'b0, t[5:0]};
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] v, input logic url);
    if (v < 6'd26) return 8'h41 + v;
    if (v < 6'd52) return 8'h61 + v - 8'd26;
    if (v < 6'd62) return 8'h30 + v - 8'd52;
    if (v == 6'd62) return url ? "-" : "+";
    return url ? "_" : "/";
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic last);
    logic [6:0]  m;
    logic [5:0]  v;
    logic [7:0]  d;
    logic        got;
    dec_result_t r;
    got = 1'b0;
    d = 8'd0;
    if (!pad_seen && !bad_seen) begin
      live_chars++;
      if (c == b64d_pkg::PAD_CHAR) begin
        pad_seen = 1'b1;
      end else begin
        m = sextet_of(c, url_mode);
        if (m[6]) begin
          bad_seen = 1'b1;
        end else begin
          v = m[5:0];
          case (phase)
            2'd1: d = {prev_sext, v[5:4]};
            2'd2: d = {prev_sext[3:0], v[5:2]};
            2'd3: d = {prev_sext[1:0], v};
            default: d = 8'd0;
          endcase
          got = (phase != 2'd0);
          prev_sext = v;
          phase = phase + 2'd1;
        end
      end
    end
    if (got || last) begin
      r.out_byte = d;
      r.byte_valid = got;
      r.end_of_string = last;
      r.status = b64d_pkg::ST_OK;
      if (last && bad_seen) r.status = b64d_pkg::ST_BAD_CHAR;
      else if (last && phase == 2'd1) r.status = b64d_pkg::ST_BAD_LEN;
      pending_decodes.push_back(r);
    end
    if (last) begin
      prev_sext = 6'd0;
      phase = 2'd0;
      pad_seen = 1'b0;
      bad_seen = 1'b0;
    end
  endfunction

  // receiver stalls
  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

  always @(posedge clk) begin : check_results
    dec_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_decodes.size() == 0) begin
        $error("unexpected transfer: out_byte %02h byte_valid %0b end_of_string %0b status %0d",
               out_ch.out_byte, out_ch.byte_valid, out_ch.end_of_string, out_ch.status);
        err_count++;
      end else begin
        want = pending_decodes.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_ch.out_byte);
          err_count++;
        end
        if (out_ch.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_ch.byte_valid);
          err_count++;
        end
        if (out_ch.end_of_string !== want.end_of_string) begin
          $error("end_of_string: expected %0b, got %0b", want.end_of_string,
                 out_ch.end_of_string);
          err_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          err_count++;
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_in <= c;
    in_ch.last_char <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_char(c, last);
  endtask

  task automatic send_text(input string s, input logic ends);
    for (int i = 0; i < s.len(); i++) send_char(s[i], ends && (i == s.len() - 1));
  endtask

  task automatic send_string();
    for (int i = 0; i < char_buf.size(); i++)
      send_char(char_buf[i], i == char_buf.size() - 1);
  endtask

  // drop valid and let every outstanding transfer and in-flight character drain
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_alphabet(input logic url);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= url;
    @(negedge clk);
    cfg_we <= 1'b0;
    url_mode = url;
  endtask

  // random bytes cut to nbytes; bits of absent bytes land in the unused low bits
  task automatic build_encoded(input int nbytes, input logic url, input logic pad);
    logic [7:0] b0, b1, b2;
    int rem;
    for (int i = 0; i < nbytes; i += 3) begin
      b0 = 8'($urandom_range(255));
      b1 = 8'($urandom_range(255));
      b2 = 8'($urandom_range(255));
      rem = nbytes - i;
      char_buf.push_back(char_of(b0[7:2], url));
      char_buf.push_back(char_of({b0[1:0], b1[7:4]}, url));
      if (rem >= 2) char_buf.push_back(char_of({b1[3:0], b2[7:6]}, url));
      if (rem >= 3) char_buf.push_back(char_of(b2[5:0], url));
      if (pad && rem == 1) begin
        char_buf.push_back(b64d_pkg::PAD_CHAR);
        char_buf.push_back(b64d_pkg::PAD_CHAR);
      end else if (pad && rem == 2) begin
        char_buf.push_back(b64d_pkg::PAD_CHAR);
      end
    end
  endtask

  task automatic build_string();
    int   kind;
    int   n;
    logic url;
    char_buf.delete();
    kind = $urandom_range(99);
    url = ($urandom_range(9) == 0) ? !url_mode : url_mode;
    if (kind < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) char_buf.push_back(8'($urandom_range(255)));
    end else if (kind < 20) begin
      // orphan: whole groups plus one data character, sometimes then a pad
      build_encoded(3 * $urandom_range(0, 3), url, 1'b0);
      char_buf.push_back(char_of(6'($urandom_range(63)), url));
      if ($urandom_range(1)) char_buf.push_back(b64d_pkg::PAD_CHAR);
    end else begin
      build_encoded($urandom_range(0, 10), url, $urandom_range(4) != 0);
      if (kind < 30 && char_buf.size() != 0)
        char_buf[$urandom_range(char_buf.size() - 1)] = 8'($urandom_range(255));
      else if (kind < 36)
        repeat ($urandom_range(1, 3)) char_buf.push_back(8'($urandom_range(255)));
    end
    if (char_buf.size() == 0)
      char_buf.push_back($urandom_range(1) ? b64d_pkg::PAD_CHAR : "A");
  endtask

  task automatic test_full_group();
    send_text("TWFu", 1'b1);
  endtask

  task automatic test_padding();
    // the 'x' after padding is ignored rather than flagged
    send_text("TQ=x", 1'b1);
  endtask

  task automatic test_length();
    send_text("A", 1'b1);
    send_char("A", 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_alphabets();
    set_alphabet(1'b0);
    send_text("Az+/", 1'b1);
    set_alphabet(1'b1);
    send_text("Za-_", 1'b1);
    // switch mid-string once the decoder has gone quiet
    send_text("9_", 1'b0);
    set_alphabet(1'b0);
    send_text("+9", 1'b1);
  endtask

  task automatic test_random(input int n);
    int target;
    target = live_chars + n;
    while (live_chars < target) begin
      build_string();
      send_string();
      if ($urandom_range(19) == 0) set_alphabet(1'($urandom_range(1)));
      else if ($urandom_range(19) == 0) wait_idle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_in = 8'd0;
    in_ch.last_char = 1'b0;
    out_ch.ready = 1'b1;
    url_mode = 1'b0;
    prev_sext = 6'd0;
    phase = 2'd0;
    pad_seen = 1'b0;
    bad_seen = 1'b0;
    live_chars = 0;
    err_count = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_full_group();
    test_padding();
    test_length();
    test_alphabets();

    set_alphabet(1'b0);
    test_random(150);
    src_idle_pct = 47;
    set_alphabet(1'b1);
    test_random(150);
    src_idle_pct = 0;
    snk_idle_pct = 47;
    set_alphabet(1'b0);
    test_random(150);
    src_idle_pct = 15;
    snk_idle_pct = 15;
    set_alphabet(1'b1);
    test_random(150);

    wait_idle();
    repeat (6) @(posedge clk);
    if (err_count == 0) begin
      $display("base64_stream_decoder verification clean");
    end else begin
      $display("base64_stream_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("base64_stream_decoder verification failed");
    $finish;
  end

endmodule

### files.f
design/b64d_pkg.sv
design/b64d_in_if.sv
design/b64d_out_if.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
bench/tb.sv
